>>> design/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// shared request and response types, card mode codes and command constants
// ----------------------------------------------------------------------------
`default_nettype none
package mmc_pkg;
	typedef struct packed {
		logic        req_type;
		logic        di;
		logic        cs_n;
		logic        sclk;
		logic [15:0] load_addr;
		logic [7:0]  load_data;
	} mmc_req_t;

	typedef struct packed {
		logic       miso;
		logic [2:0] card_mode;
	} mmc_rsp_t;

	typedef enum logic [2:0] {
		MD_POWERUP    = 3'd0,
		MD_IDLE       = 3'd1,
		MD_CMD        = 3'd2,
		MD_CMD_RESP   = 3'd3,
		MD_READ_RESP  = 3'd4,
		MD_READ       = 3'd5,
		MD_WRITE_RESP = 3'd6,
		MD_WRITE      = 3'd7
	} mmc_mode_t;

	localparam logic [7:0] CMD_GO_IDLE   = 8'h40;
	localparam logic [7:0] CMD_SEND_OP   = 8'h41;
	localparam logic [7:0] CMD_SET_BLEN  = 8'h50;
	localparam logic [7:0] CMD_READ_BLK  = 8'h51;
	localparam logic [7:0] CMD_WRITE_BLK = 8'h58;
	localparam logic [7:0] CRC_CMD0      = 8'h95;
	localparam logic [7:0] R1_IDLE       = 8'h01;
	localparam logic [6:0] IDLE_CLK_MIN  = 7'd74;
	localparam logic [5:0] READ_WAIT     = 6'd5;
	localparam logic [5:0] WRITE_WAIT    = 6'd40;
	localparam logic [15:0] BLKSZ_RESET  = 16'd256;
endpackage
`default_nettype wire

>>> design/mmc_ram.sv
// ----------------------------------------------------------------------------
// mmc_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module mmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> design/mmc_spi_card_slave.sv
// ----------------------------------------------------------------------------
// mmc_spi_card_slave
// mmc card in spi mode, driven by one pin sample per request
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// in      | in_valid/in_ready  | mmc_req_t (pin sample or disk preload)
// out     | out_valid/out_ready| mmc_rsp_t (miso, card mode)
//
// a pin sample is handled in two steps: the disk byte for a possible read
// is fetched from the disk ram at accept, then the card state updates in
// stage 1. a preload is a single ram write. one response per request.
// an output register parts the two sides; a request is accepted only when
// that register is empty or its response is taken in the same cycle, and
// never while stage 1 holds a sample.
// a new block base goes through base_pend_q into base_q after its decode.
// reset clears all control state; the disk ram holds no reset value.
// ----------------------------------------------------------------------------
`default_nettype none
module mmc_spi_card_slave #(
	parameter int DISK_BYTES = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire mmc_pkg::mmc_req_t in_data,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      mmc_pkg::mmc_rsp_t out_data
);
	import mmc_pkg::*;

	localparam int AW = $clog2(DISK_BYTES);

	// card state
	logic        prev_sclk_q, prev_cs_q;
	logic [47:0] shift_q;
	logic [5:0]  bit_cnt_q;
	logic [6:0]  idle_clk_q;
	mmc_mode_t   mode_q;
	logic        init_flag_q;
	logic [1:0]  init_cnt_q;
	logic [15:0] blk_size_q;
	logic        wait_desel_q, out_level_q;
	logic [7:0]  resp_byte_q;
	logic        resp_pend_q;
	logic [2:0]  resp_pos_q;
	logic [5:0]  resp_wait_q;
	logic [16:0] rd_idx_q;
	logic [15:0] wr_idx_q;
	logic [16:0] xfer_len_q;
	logic [AW-1:0] base_q;       // block_addr * block_size mod disk size

	// stage 1 holds the pins of an accepted sample while the ram read completes
	logic      busy_s1;
	logic      di_s1, cs_n_s1, sclk_s1;

	// ram port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata, ram_rdata;

	mmc_ram #(.WIDTH(8), .DEPTH(DISK_BYTES)) u_disk (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// output slot free at the end of this cycle
	logic out_free;
	assign out_free = !out_valid || out_ready;
	// accept when not finishing a sample and the output is free
	assign in_ready = !busy_s1 && out_free;
	logic acc;
	assign acc = in_valid && in_ready;

	// next-state values, computed from the stage 1 pins
	logic        n_prev_sclk, n_prev_cs;
	logic [47:0] n_shift;
	logic [5:0]  n_bit_cnt;
	logic [6:0]  n_idle_clk;
	mmc_mode_t   n_mode;
	logic        n_init_flag;
	logic [1:0]  n_init_cnt;
	logic [15:0] n_blk_size;
	logic        n_wait_desel, n_out_level;
	logic [7:0]  n_resp_byte;
	logic        n_resp_pend;
	logic [2:0]  n_resp_pos;
	logic [5:0]  n_resp_wait;
	logic [16:0] n_rd_idx;
	logic [15:0] n_wr_idx;
	logic [16:0] n_xfer_len;
	logic [31:0] n_blk_addr;
	logic        n_load_base;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]  wr_byte;

	// base address multiply is registered; a new block address is only set by
	// a decode, and the next use is at least one sclk edge later
	logic [31:0] blk_addr_q;
	logic        base_pend_q;
	logic [47:0] prod;
	assign prod = blk_addr_q * blk_size_q;

	always_comb begin
		logic pos, neg, sel, cs_edge, done, level;
		logic [7:0] rbyte;
		logic [16:0] ri;
		logic [15:0] wi;
		pos = sclk_s1 && !prev_sclk_q;
		neg = !sclk_s1 && prev_sclk_q;
		sel = !cs_n_s1;
		cs_edge = cs_n_s1 != prev_cs_q;
		done = 1'b0;
		level = 1'b0;
		ri = '0;
		wi = '0;
		n_prev_sclk = sclk_s1;
		n_prev_cs = cs_n_s1;
		n_shift = shift_q; n_bit_cnt = bit_cnt_q; n_idle_clk = idle_clk_q;
		n_mode = mode_q; n_init_flag = init_flag_q; n_init_cnt = init_cnt_q;
		n_blk_size = blk_size_q; n_wait_desel = wait_desel_q;
		n_out_level = out_level_q; n_resp_byte = resp_byte_q;
		n_resp_pend = resp_pend_q; n_resp_pos = resp_pos_q;
		n_resp_wait = resp_wait_q; n_rd_idx = rd_idx_q; n_wr_idx = wr_idx_q;
		n_xfer_len = xfer_len_q; n_blk_addr = blk_addr_q; n_load_base = 1'b0;
		wr_en = 1'b0;
		wr_addr = base_q + AW'(wr_idx_q);
		wr_byte = 8'd0;
		rbyte = (rd_idx_q < {1'b0, blk_size_q}) ? ram_rdata : 8'd0;

		if (cs_edge && sel) begin
			n_shift = '0; n_bit_cnt = '0; n_resp_pos = '0;
		end
		if (cs_edge && !sel) begin
			n_out_level = 1'b0; n_wait_desel = 1'b0;
		end
		// a deselect edge ends the wait in the same sample
		if (n_wait_desel) begin
			done = 1'b1;
		end
		if (!done) begin
			if (sel && !pos && !neg && (mode_q == MD_READ_RESP ||
				mode_q == MD_WRITE_RESP) && resp_wait_q != 6'd0) begin
				n_out_level = 1'b1;
			end
			if (pos && sel) begin
				n_idle_clk = '0;
				n_shift = {n_shift[46:0], di_s1};
				if (n_bit_cnt != 6'd63) begin
					n_bit_cnt = n_bit_cnt + 6'd1;
				end
				case (mode_q)
					MD_READ_RESP, MD_WRITE_RESP: begin
						if (n_bit_cnt == 6'd8) begin
							if (n_resp_wait != 6'd0) begin
								n_resp_wait = n_resp_wait - 6'd1;
								if (n_resp_wait == 6'd0) begin
									n_wait_desel = 1'b1;
								end
							end else if (mode_q == MD_READ_RESP) begin
								ri = n_rd_idx + 17'd1;
								n_rd_idx = ri;
								n_mode = (ri == n_xfer_len) ? MD_CMD : MD_READ;
								n_resp_byte = rbyte; n_resp_pend = 1'b1;
								n_resp_pos = '0; n_resp_wait = '0;
								n_wait_desel = 1'b1;
							end else begin
								n_mode = MD_WRITE;
							end
							n_bit_cnt = '0;
						end
					end
					MD_READ: begin
						if (!resp_pend_q) begin
							ri = n_rd_idx + 17'd1;
							n_rd_idx = ri;
							if (ri == n_xfer_len) begin
								n_mode = MD_CMD;
							end
							n_resp_byte = rbyte; n_resp_pend = 1'b1;
							n_resp_pos = '0; n_resp_wait = '0;
							n_wait_desel = 1'b1;
						end
					end
					MD_WRITE: begin
						if (n_bit_cnt == 6'd8) begin
							if ({1'b0, wr_idx_q} < {1'b0, blk_size_q}) begin
								wr_en = 1'b1;
								wr_byte = n_shift[7:0];
							end
							wi = wr_idx_q + 16'd1;
							n_wr_idx = wi;
							if ({1'b0, wi} == n_xfer_len) begin
								n_shift = '0;
								n_mode = MD_CMD;
							end
						end
					end
					MD_IDLE, MD_CMD: begin
						if (n_bit_cnt == 6'd48) begin
							done = 1'b1;
							case (n_shift[47:40])
								CMD_GO_IDLE: begin
									if (n_shift[7:0] == CRC_CMD0) begin
										n_mode = MD_CMD_RESP; n_init_flag = 1'b0;
										n_resp_byte = R1_IDLE; n_resp_pend = 1'b1;
										n_resp_pos = '0; n_resp_wait = '0;
									end
								end
								CMD_SEND_OP: begin
									n_init_flag = 1'b1; n_init_cnt = '0;
									n_mode = MD_CMD_RESP;
									n_resp_byte = R1_IDLE; n_resp_pend = 1'b1;
									n_resp_pos = '0; n_resp_wait = '0;
								end
								CMD_SET_BLEN: begin
									n_blk_size = n_shift[23:8];
									n_load_base = 1'b1;
									n_mode = MD_CMD_RESP;
									n_resp_byte = 8'd0; n_resp_pend = 1'b1;
									n_resp_pos = '0; n_resp_wait = '0;
								end
								CMD_READ_BLK, CMD_WRITE_BLK: begin
									n_blk_addr = n_shift[39:8];
									n_load_base = 1'b1;
									n_rd_idx = '0; n_wr_idx = '0;
									n_resp_byte = 8'd0; n_resp_pend = 1'b1;
									n_resp_pos = '0;
									if (n_shift[47:40] == CMD_READ_BLK) begin
										n_xfer_len = {1'b0, blk_size_q} + 17'd2;
										n_resp_wait = READ_WAIT;
										n_mode = MD_READ_RESP;
									end else begin
										n_xfer_len = {1'b0, blk_size_q};
										n_resp_wait = WRITE_WAIT;
										n_mode = MD_WRITE_RESP;
									end
								end
								default: ;
							endcase
							n_bit_cnt = '0;
						end
					end
					default: ;
				endcase
			end
		end
		if (!done) begin
			if (pos && !sel && di_s1) begin
				if (n_idle_clk != 7'd127) begin
					n_idle_clk = n_idle_clk + 7'd1;
				end
				if (n_idle_clk >= IDLE_CLK_MIN) begin
					n_mode = MD_IDLE;
				end
			end
			level = n_out_level;
			if (n_mode == MD_CMD_RESP || n_mode == MD_READ_RESP ||
				n_mode == MD_WRITE_RESP || n_mode == MD_READ) begin
				if (pos && sel && n_init_flag && !n_resp_pend) begin
					n_init_cnt = n_init_cnt + 2'd1;
					if (n_init_cnt == 2'd3) begin
						n_init_flag = 1'b0;
					end
					n_resp_byte = n_init_flag ? R1_IDLE : 8'd0;
					n_resp_pend = 1'b1; n_resp_pos = '0; n_resp_wait = '0;
				end
				if ((neg && sel) || (cs_edge && sel)) begin
					if (!n_resp_pend) begin
						n_mode = MD_CMD;
					end else if (n_resp_wait == 6'd0) begin
						level = n_resp_byte[3'd7 - n_resp_pos];
						n_resp_pos = n_resp_pos + 3'd1;
						if (n_resp_pos == 3'd0) begin
							n_resp_pend = 1'b0;
						end
					end
				end
			end
			n_out_level = level;
		end
	end

	// ram access: preload writes at accept; a sample reads at accept and
	// may write back in stage 1
	always_comb begin
		ram_we = 1'b0;
		ram_addr = base_q + AW'(rd_idx_q);
		ram_wdata = wr_byte;
		if (busy_s1) begin
			ram_we = wr_en;
			ram_addr = wr_addr;
		end else if (acc && in_data.req_type) begin
			ram_we = 1'b1;
			ram_addr = AW'(in_data.load_addr);
			ram_wdata = in_data.load_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			out_valid <= 1'b0;
			prev_sclk_q <= 1'b0; prev_cs_q <= 1'b0;
			shift_q <= '0; bit_cnt_q <= '0; idle_clk_q <= '0;
			mode_q <= MD_POWERUP; init_flag_q <= 1'b0; init_cnt_q <= '0;
			blk_size_q <= BLKSZ_RESET; wait_desel_q <= 1'b0;
			out_level_q <= 1'b0; resp_byte_q <= '0; resp_pend_q <= 1'b0;
			resp_pos_q <= '0; resp_wait_q <= '0; rd_idx_q <= '0;
			wr_idx_q <= '0; xfer_len_q <= '0; blk_addr_q <= '0;
			base_q <= '0; base_pend_q <= 1'b0;
			out_data <= '0;
		end else begin
			// a new response replaces one taken in the same cycle
			if ((acc && in_data.req_type) || busy_s1) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (base_pend_q) begin
				base_q <= AW'(prod);
				base_pend_q <= 1'b0;
			end
			if (acc && in_data.req_type) begin
				// preload: report current pins state unchanged
				out_data.miso <= out_level_q;
				out_data.card_mode <= mode_q;
			end else if (acc) begin
				busy_s1 <= 1'b1;
			end
			if (busy_s1) begin
				busy_s1 <= 1'b0;
				prev_sclk_q <= n_prev_sclk; prev_cs_q <= n_prev_cs;
				shift_q <= n_shift; bit_cnt_q <= n_bit_cnt;
				idle_clk_q <= n_idle_clk; mode_q <= n_mode;
				init_flag_q <= n_init_flag; init_cnt_q <= n_init_cnt;
				blk_size_q <= n_blk_size; wait_desel_q <= n_wait_desel;
				out_level_q <= n_out_level; resp_byte_q <= n_resp_byte;
				resp_pend_q <= n_resp_pend; resp_pos_q <= n_resp_pos;
				resp_wait_q <= n_resp_wait; rd_idx_q <= n_rd_idx;
				wr_idx_q <= n_wr_idx; xfer_len_q <= n_xfer_len;
				blk_addr_q <= n_blk_addr;
				if (n_load_base) begin
					base_pend_q <= 1'b1;
				end
				out_data.miso <= n_out_level;
				out_data.card_mode <= n_mode;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			di_s1 <= in_data.di;
			cs_n_s1 <= in_data.cs_n;
			sclk_s1 <= in_data.sclk;
		end
	end
endmodule
`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// pin-level stimulus for the mmc spi card slave, checked against a predictor
// ----------------------------------------------------------------------------
// a disk byte that was never written is preloaded just before a read can
// reach it, so no read ever sees an unwritten byte. directed tests cover
// power-up, every command, bad crc, unknown codes and block sizes of zero
// and more. a random phase then sends command frames followed by byte
// transfers, with noise, preloads and power-up clocks mixed in. every
// response is compared field by field with the predicted miso level and
// card mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import mmc_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int LONG_HOLD = 400;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	mmc_req_t  in_data;
	logic      out_valid;
	logic      out_ready;
	mmc_rsp_t  out_data;

	mmc_spi_card_slave DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// card state as the predictor sees it
	bit          p_sclk, p_cs;
	logic [47:0] frame_sh;
	int unsigned bits, idle_clk, init_cnt, blk_size;
	bit          init_fl, wait_desel, out_lvl, rsp_pend;
	int unsigned rsp_byte, rsp_pos, rsp_wait;
	int unsigned rd_idx, wr_idx, xfer_len, blk_addr;
	mmc_mode_t   mode;
	logic [7:0]  disk [0:65535];
	bit          written [0:65535];

	mmc_rsp_t    pending_rsp [$];
	int          mismatches;
	int          cycles;
	int          sent;
	bit          no_idle;
	bit          hold_rx;
	bit          start_hold;

	function automatic logic [15:0] disk_addr(int unsigned idx);
		longint unsigned a;
		a = longint'(blk_addr) * longint'(blk_size) + longint'(idx);
		return a[15:0];
	endfunction

	function automatic void queue_byte(int unsigned b, int unsigned w);
		rsp_byte = b & 8'hff;
		rsp_pend = 1'b1;
		rsp_pos = 0;
		rsp_wait = w & 6'h3f;
	endfunction

	function automatic void fetch_byte();
		int unsigned b;
		b = 0;
		if (rd_idx < blk_size)
			b = 32'(disk[disk_addr(rd_idx)]);
		rd_idx = (rd_idx + 1) & 17'h1ffff;
		if (rd_idx == xfer_len)
			mode = MD_CMD;
		queue_byte(b, 0);
	endfunction

	function automatic void store_byte();
		if (wr_idx < blk_size) begin
			disk[disk_addr(wr_idx)] = frame_sh[7:0];
			written[disk_addr(wr_idx)] = 1'b1;
		end
		wr_idx = (wr_idx + 1) & 16'hffff;
		if (wr_idx == xfer_len) begin
			frame_sh = '0;
			mode = MD_CMD;
		end
	endfunction

	function automatic void decode_frame();
		logic [7:0] code;
		code = frame_sh[47:40];
		case (code)
			CMD_GO_IDLE: begin
				if (frame_sh[7:0] == CRC_CMD0) begin
					mode = MD_CMD_RESP;
					init_fl = 1'b0;
					queue_byte(32'(R1_IDLE), 0);
				end
			end
			CMD_SEND_OP: begin
				init_fl = 1'b1;
				init_cnt = 0;
				mode = MD_CMD_RESP;
				queue_byte(32'(R1_IDLE), 0);
			end
			CMD_SET_BLEN: begin
				blk_size = 32'(frame_sh[23:8]);
				mode = MD_CMD_RESP;
				queue_byte(0, 0);
			end
			CMD_READ_BLK: begin
				blk_addr = frame_sh[39:8];
				xfer_len = blk_size + 2;
				rd_idx = 0;
				wr_idx = 0;
				queue_byte(0, 32'(READ_WAIT));
				mode = MD_READ_RESP;
			end
			CMD_WRITE_BLK: begin
				blk_addr = frame_sh[39:8];
				xfer_len = blk_size;
				rd_idx = 0;
				wr_idx = 0;
				queue_byte(0, 32'(WRITE_WAIT));
				mode = MD_WRITE_RESP;
			end
			default: ;
		endcase
		bits = 0;
	endfunction

	// expected response to one request, updating the predicted card state
	function automatic mmc_rsp_t card_step(mmc_req_t r);
		bit pos, neg, sel, cs_edge, lvl, decoded;
		mmc_rsp_t o;
		decoded = 1'b0;
		if (r.req_type) begin
			disk[r.load_addr] = r.load_data;
			written[r.load_addr] = 1'b1;
		end else begin
			pos = r.sclk && !p_sclk;
			neg = !r.sclk && p_sclk;
			p_sclk = r.sclk;
			sel = !r.cs_n;
			cs_edge = (r.cs_n != p_cs);
			p_cs = r.cs_n;
			if (cs_edge && sel) begin
				frame_sh = '0;
				bits = 0;
				rsp_pos = 0;
			end
			if (cs_edge && !sel) begin
				out_lvl = 1'b0;
				wait_desel = 1'b0;
			end
			if (!wait_desel) begin
				// busy level while a response delay runs
				if (sel && !pos && !neg && (mode == MD_READ_RESP ||
						mode == MD_WRITE_RESP) && rsp_wait != 0)
					out_lvl = 1'b1;
				if (pos && sel) begin
					idle_clk = 0;
					frame_sh = {frame_sh[46:0], r.di};
					if (bits < 63)
						bits++;
					case (mode)
						MD_READ_RESP, MD_WRITE_RESP: begin
							if (bits == 8) begin
								if (rsp_wait > 0) begin
									rsp_wait--;
									if (rsp_wait == 0)
										wait_desel = 1'b1;
								end else if (mode == MD_READ_RESP) begin
									mode = MD_READ;
									fetch_byte();
									wait_desel = 1'b1;
								end else begin
									mode = MD_WRITE;
								end
								bits = 0;
							end
						end
						MD_READ: begin
							if (!rsp_pend) begin
								fetch_byte();
								wait_desel = 1'b1;
							end
						end
						MD_WRITE: begin
							if (bits == 8)
								store_byte();
						end
						MD_IDLE, MD_CMD: begin
							if (bits == 48) begin
								decode_frame();
								decoded = 1'b1;
							end
						end
						default: ;
					endcase
				end
				if (!decoded) begin
					// power-up clocks with the card deselected
					if (pos && !sel && r.di) begin
						if (idle_clk < 127)
							idle_clk++;
						if (idle_clk >= IDLE_CLK_MIN)
							mode = MD_IDLE;
					end
					lvl = out_lvl;
					if (mode == MD_CMD_RESP || mode == MD_READ_RESP ||
							mode == MD_WRITE_RESP || mode == MD_READ) begin
						if (pos && sel && init_fl && !rsp_pend) begin
							init_cnt = (init_cnt + 1) & 3;
							if (init_cnt > 2)
								init_fl = 1'b0;
							queue_byte(init_fl ? 32'(R1_IDLE) : 32'd0, 0);
						end
						// response bits leave msb first on falling edges or a select edge
						if ((neg && sel) || (cs_edge && sel)) begin
							if (!rsp_pend) begin
								mode = MD_CMD;
							end else if (rsp_wait == 0) begin
								lvl = rsp_byte[7 - (rsp_pos & 7)];
								rsp_pos++;
								if (rsp_pos >= 8) begin
									rsp_pos = 0;
									rsp_pend = 1'b0;
								end
							end
						end
					end
					out_lvl = lvl;
				end
			end
		end
		o.miso = out_lvl;
		o.card_mode = mode;
		return o;
	endfunction

	// one request, with a random gap in front unless idling is off
	task automatic send_req(mmc_req_t r);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 12));
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		pending_rsp.push_back(card_step(r));
		sent++;
	endtask

	// a pin sample; the next byte a read may fetch is preloaded first if unwritten
	task automatic pin(bit di, bit cs_n, bit sclk);
		mmc_req_t r;
		logic [15:0] a;
		a = disk_addr(rd_idx);
		if ((mode == MD_READ_RESP || mode == MD_READ) && rd_idx < blk_size &&
				!written[a])
			preload(a, 8'($urandom));
		r.req_type = 1'b0;
		r.di = di;
		r.cs_n = cs_n;
		r.sclk = sclk;
		r.load_addr = 16'($urandom);
		r.load_data = 8'($urandom);
		send_req(r);
	endtask

	task automatic preload(logic [15:0] a, logic [7:0] d);
		mmc_req_t r;
		r.req_type = 1'b1;
		r.di = 1'($urandom);
		r.cs_n = 1'($urandom);
		r.sclk = 1'($urandom);
		r.load_addr = a;
		r.load_data = d;
		send_req(r);
	endtask

	// bits msb first, data set up on low sclk and taken on the rise
	task automatic clock_bits(logic [47:0] v, int n);
		for (int i = n - 1; i >= 0; i--) begin
			pin(v[i], 1'b0, 1'b0);
			pin(v[i], 1'b0, 1'b1);
		end
		pin(1'b1, 1'b0, 1'b0);
	endtask

	// one selection carrying one byte, then deselect
	task automatic byte_xfer(logic [7:0] b);
		pin(1'b1, 1'b0, 1'b0);
		clock_bits({40'h0, b}, 8);
		pin(1'b1, 1'b1, 1'b0);
	endtask

	task automatic command(logic [7:0] code, logic [31:0] arg, logic [7:0] crc,
			int follow);
		pin(1'b1, 1'b0, 1'b0);
		clock_bits({code, arg, crc}, 48);
		clock_bits(48'hff, 8);
		pin(1'b1, 1'b1, 1'b0);
		repeat (follow) byte_xfer(8'($urandom));
	endtask

	task automatic power_clocks(int n, bit di);
		repeat (n) begin
			pin(di, 1'b1, 1'b1);
			pin(di, 1'b1, 1'b0);
		end
	endtask

	// stop sending until every predicted response is in
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic test_power_up();
		repeat (6) pin(1'($urandom), 1'($urandom), 1'($urandom));
		power_clocks(10, 1'b0);
		power_clocks(80, 1'b1);
		drain();
	endtask

	task automatic test_commands();
		command(CMD_GO_IDLE, 32'h0, 8'h00, 0);      // bad crc, ignored
		command(CMD_GO_IDLE, 32'h0, CRC_CMD0, 1);
		command(CMD_SEND_OP, 32'hffffffff, 8'hff, 5);
		command(8'h7f, 32'h12345678, 8'h01, 1);       // unknown code
		command(CMD_SET_BLEN, 32'h0000_0004, 8'h01, 1);
		command(CMD_READ_BLK, 32'h0000_0010, 8'h01, 12);
		command(CMD_WRITE_BLK, 32'h0000_0010, 8'h01, 46);
		command(CMD_READ_BLK, 32'h0000_0010, 8'h01, 12);
		command(CMD_SET_BLEN, 32'h0000_0000, 8'h01, 1);
		command(CMD_READ_BLK, 32'hffffffff, 8'h01, 9);  // crc bytes only
		command(CMD_SET_BLEN, 32'h0000_0010, 8'h01, 1);
		command(CMD_READ_BLK, 32'hffffffff, 8'h01, 24);
		drain();
	endtask

	task automatic test_random();
		int first, kind, n;
		logic [7:0] code;
		logic [31:0] arg;
		first = sent;
		while (sent - first < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if (sent - first > RANDOM_ITEMS / 2 && !start_hold)
				start_hold = 1'b1;
			kind = int'($urandom_range(0, 9));
			if (kind < 6) begin
				case ($urandom_range(0, 5))
					0: code = CMD_GO_IDLE;
					1: code = CMD_SEND_OP;
					2: code = CMD_SET_BLEN;
					3: code = CMD_READ_BLK;
					4: code = CMD_WRITE_BLK;
					default: code = 8'($urandom);
				endcase
				arg = $urandom;
				if (code == CMD_SET_BLEN)
					arg[15:0] = 16'($urandom_range(0, 8));
				n = (code == CMD_WRITE_BLK) ? int'($urandom_range(40, 50))
					: int'($urandom_range(1, 12));
				command(code, arg, $urandom_range(0, 1) ? CRC_CMD0 : 8'($urandom), n);
			end else if (kind < 8) begin
				repeat ($urandom_range(1, 20))
					pin(1'($urandom), 1'($urandom), 1'($urandom));
			end else if (kind == 8) begin
				preload(16'($urandom), 8'($urandom));
			end else begin
				power_clocks(int'($urandom_range(1, 80)), 1'b1);
			end
			if ($urandom_range(0, 15) == 0)
				drain();
		end
		no_idle = 1'b0;
		drain();
	endtask

	// long receiver hold-off, counted here so the sender keeps going
	initial begin
		hold_rx = 1'b0;
		wait (start_hold);
		@(negedge clk);
		hold_rx = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_rx = 1'b0;
	end

	// receiver: random stall before each response, plus the long hold
	initial begin
		int rx_wait;
		rx_wait = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx || rx_wait > 0) begin
				out_ready <= 1'b0;
				if (!hold_rx)
					rx_wait--;
			end else begin
				out_ready <= 1'b1;
			end
			@(posedge clk);
			if (out_valid && out_ready)
				rx_wait = no_idle ? 0 : int'($urandom_range(0, 12));
		end
	end

	// response check
	always @(posedge clk) begin
		mmc_rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response miso=%0b mode=%0d",
						out_data.miso, out_data.card_mode);
			end else begin
				want = pending_rsp.pop_front();
				if (want.miso !== out_data.miso ||
						want.card_mode !== out_data.card_mode) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected miso=%0b mode=%0d, got miso=%0b mode=%0d",
							want.miso, want.card_mode, out_data.miso, out_data.card_mode);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		sent = 0;
		no_idle = 1'b0;
		start_hold = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		p_sclk = 1'b0;
		p_cs = 1'b0;
		frame_sh = '0;
		bits = 0;
		idle_clk = 0;
		init_cnt = 0;
		blk_size = 32'(BLKSZ_RESET);
		init_fl = 1'b0;
		wait_desel = 1'b0;
		out_lvl = 1'b0;
		rsp_pend = 1'b0;
		rsp_byte = 0;
		rsp_pos = 0;
		rsp_wait = 0;
		rd_idx = 0;
		wr_idx = 0;
		xfer_len = 0;
		blk_addr = 0;
		mode = MD_POWERUP;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_power_up();
		test_commands();
		test_random();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
